FILE: rtl/fbm_value_noise_2d_assert.svh
// Assertion macros for the fractal value noise RTL (used by the result buffer).
`ifndef FBM_VALUE_NOISE_2D_ASSERT_SVH
`define FBM_VALUE_NOISE_2D_ASSERT_SVH
`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define FBM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define FBM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define FBM_ASSERT(label, prop, msg)
`define FBM_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

FILE: rtl/fbm_pkg.sv
// Types and constants shared by the fractal value noise modules.
package fbm_pkg;
   localparam int FRAC_BITS = 24;
   localparam int OCT_LAT = 6;

   typedef logic [63:0] coord_type;
   typedef logic [23:0] frac_type;
   typedef logic [23:0] sum_type;
   typedef logic [24:0] weight_type;
   typedef logic [1:0]  csr_index_type;

   typedef struct packed {
      logic       advance;
      logic       add_en;
      logic [7:0] offset;
   } oct_ctl_type;

   localparam weight_type ONE_F = 25'h100_0000;
   localparam logic [21:0] HASH_K = 22'((64'd13 << FRAC_BITS) / 64'd100);
   localparam logic [25:0] HASH_C =
      26'((64'd3 << FRAC_BITS) + ((64'd333 << FRAC_BITS) / 64'd1000));
   localparam logic [31:0] ROT_COS = 32'd3769188402;
   localparam logic [31:0] ROT_SIN = 32'd2059117009;

   localparam csr_index_type CSR_OCTAVE_COUNT  = 2'd0;
   localparam csr_index_type CSR_OCTAVE_OFFSET = 2'd1;

   localparam logic [3:0] OCTAVE_COUNT_RESET  = 4'd5;
   localparam logic [7:0] OCTAVE_OFFSET_RESET = 8'd100;
endpackage

FILE: rtl/fbm_value_noise_2d.sv
// Fractal value noise: takes one point per cycle while the result buffer is not
// full, through a chain of MAX_OCTAVES octave stages; octaves past octave_count
// run but add nothing. The whole pipeline advances together and holds only
// while the two-entry result buffer is full.
module fbm_value_noise_2d #(
   parameter int MAX_OCTAVES = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [31:0]     req_x_coord,
   input  logic signed [31:0]     req_y_coord,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [15:0]            rsp_noise_value,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  fbm_pkg::csr_index_type csr_index,
   input  logic [7:0]             csr_data
);
   import fbm_pkg::*;

   logic [3:0] octave_count_ff;
   logic [7:0] octave_offset_ff;
   logic       full;
   logic       advance;

   logic      chain_valid [MAX_OCTAVES+1];
   coord_type chain_x [MAX_OCTAVES+1];
   coord_type chain_y [MAX_OCTAVES+1];
   sum_type   chain_sum [MAX_OCTAVES+1];

   assign csr_ready = 1'b1;
   assign advance   = !full;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         octave_count_ff  <= OCTAVE_COUNT_RESET;
         octave_offset_ff <= OCTAVE_OFFSET_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_OCTAVE_COUNT:  octave_count_ff  <= csr_data[3:0];
            CSR_OCTAVE_OFFSET: octave_offset_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // widen Q16.16 to the internal fraction width
   assign chain_valid[0] = req_valid && advance;
   assign chain_x[0]     = {{24{req_x_coord[31]}}, req_x_coord, 8'd0};
   assign chain_y[0]     = {{24{req_y_coord[31]}}, req_y_coord, 8'd0};
   assign chain_sum[0]   = '0;

   for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
      oct_ctl_type ctl;
      // octave zero always counts
      assign ctl.advance = advance;
      assign ctl.add_en  = (k == 0) || (5'(k) < {1'b0, octave_count_ff});
      assign ctl.offset  = octave_offset_ff;

      fbm_octave #(.OCT_INDEX(k)) u_octave (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .in_valid  (chain_valid[k]),
         .in_x      (chain_x[k]),
         .in_y      (chain_y[k]),
         .in_sum    (chain_sum[k]),
         .out_valid (chain_valid[k+1]),
         .out_x     (chain_x[k+1]),
         .out_y     (chain_y[k+1]),
         .out_sum   (chain_sum[k+1])
      );
   end

   fbm_out_buf u_out_buf (
      .clock           (clock),
      .reset           (reset),
      .push            (chain_valid[MAX_OCTAVES] && advance),
      .push_data       (chain_sum[MAX_OCTAVES][23:8]),
      .full            (full),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_noise_value (rsp_noise_value)
   );
endmodule

FILE: rtl/fbm_rotate.sv
// Four-stage rotation by 0.5 rad, doubling and offset of one point.
module fbm_rotate (
   input  logic              clock,
   input  logic              advance,
   input  logic [7:0]        offset,
   input  fbm_pkg::coord_type in_x,
   input  fbm_pkg::coord_type in_y,
   output fbm_pkg::coord_type out_x,
   output fbm_pkg::coord_type out_y
);
   import fbm_pkg::*;

   // partial products: 0 x*cos, 1 x*sin, 2 y*cos, 3 y*sin
   logic [63:0] hi_ff [4];
   logic [31:0] lo_ff [4];
   logic [63:0] hi_in [4];
   logic [31:0] lo_in [4];
   logic [63:0] rot_ff [4];
   logic [63:0] rot_in [4];
   coord_type   nx_ff, ny_ff, nx_in, ny_in;
   coord_type   ox_ff, oy_ff, ox_in, oy_in;

   always_comb begin
      logic signed [64:0] hp [4];
      logic [63:0]        lp [4];
      hp[0] = $signed(in_x[63:32]) * $signed({1'b0, ROT_COS});
      hp[1] = $signed(in_x[63:32]) * $signed({1'b0, ROT_SIN});
      hp[2] = $signed(in_y[63:32]) * $signed({1'b0, ROT_COS});
      hp[3] = $signed(in_y[63:32]) * $signed({1'b0, ROT_SIN});
      lp[0] = 64'(in_x[31:0]) * 64'(ROT_COS);
      lp[1] = 64'(in_x[31:0]) * 64'(ROT_SIN);
      lp[2] = 64'(in_y[31:0]) * 64'(ROT_COS);
      lp[3] = 64'(in_y[31:0]) * 64'(ROT_SIN);
      for (int j = 0; j < 4; j++) begin
         hi_in[j]  = hp[j][63:0];
         lo_in[j]  = lp[j][63:32];
         rot_in[j] = hi_ff[j] + {32'd0, lo_ff[j]};
      end
      nx_in = rot_ff[0] - rot_ff[3];
      ny_in = rot_ff[1] + rot_ff[2];
      ox_in = {nx_ff[62:0], 1'b0} + {32'd0, offset, 24'd0};
      oy_in = {ny_ff[62:0], 1'b0} + {32'd0, offset, 24'd0};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int j = 0; j < 4; j++) begin
            hi_ff[j]  <= hi_in[j];
            lo_ff[j]  <= lo_in[j];
            rot_ff[j] <= rot_in[j];
         end
         nx_ff <= nx_in;
         ny_ff <= ny_in;
         ox_ff <= ox_in;
         oy_ff <= oy_in;
      end
   end

   assign out_x = ox_ff;
   assign out_y = oy_ff;
endmodule

FILE: rtl/fbm_octave.sv
// One octave: six-stage lattice noise with smoothstep blend, plus rotation.
module fbm_octave #(
   parameter int OCT_INDEX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fbm_pkg::oct_ctl_type ctl,
   input  logic                 in_valid,
   input  fbm_pkg::coord_type   in_x,
   input  fbm_pkg::coord_type   in_y,
   input  fbm_pkg::sum_type     in_sum,
   output logic                 out_valid,
   output fbm_pkg::coord_type   out_x,
   output fbm_pkg::coord_type   out_y,
   output fbm_pkg::sum_type     out_sum
);
   import fbm_pkg::*;

   localparam int SHIFT = OCT_INDEX + 1;

   logic [OCT_LAT-1:0] valid_ff, valid_in;
   sum_type sum_ff [OCT_LAT];

   // stage 1
   frac_type px_ff [2], py_ff [2], px_in [2], py_in [2];
   frac_type fx_ff, fy_ff, fx2_ff, fy2_ff, fx2_in, fy2_in;
   // stage 2
   logic [26:0] m1_ff [4], m2_ff [4], m3_ff [4], m1_in [4], m2_in [4], m3_in [4];
   frac_type    cpx_ff [4], cpy_ff [4], cpx_in [4], cpy_in [4];
   frac_type    fx2b_ff, fy2b_ff, fx3_ff, fy3_ff, fx3_in, fy3_in;
   // stage 3
   logic [29:0] s01_ff [4], s01_in [4];
   logic [28:0] s2_ff [4], s2_in [4];
   weight_type  ux_ff, uy_ff, ux_in, uy_in;
   // stage 4
   frac_type    h_ff [4], h_in [4];
   weight_type  w_ff [4], w_in [4];
   // stage 5
   frac_type    t_ff [4], t_in [4];
   // stage 6
   sum_type     out_sum_in;

   coord_type rx_ff [2], ry_ff [2];
   coord_type rot_x, rot_y;

   fbm_rotate u_rotate (
      .clock   (clock),
      .advance (ctl.advance),
      .offset  (ctl.offset),
      .in_x    (in_x),
      .in_y    (in_y),
      .out_x   (rot_x),
      .out_y   (rot_y)
   );

   always_comb begin
      logic [23:0] ix [2], iy [2];
      logic [45:0] kx [2], ky [2];
      logic [47:0] fxs, fys, fxc, fyc;
      logic [50:0] p1, p2, p3;
      logic [28:0] dot;
      logic [25:0] uxr, uyr;
      weight_type  vx, vy;
      weight_type  wx [4], wy [4];
      logic [58:0] hp;
      logic [49:0] wp;
      logic [48:0] tp;
      logic [25:0] noise;

      valid_in = {valid_ff[OCT_LAT-2:0], in_valid};

      ix[0] = in_x[47:24];
      ix[1] = ix[0] + 24'd1;
      iy[0] = in_y[47:24];
      iy[1] = iy[0] + 24'd1;
      for (int i = 0; i < 2; i++) begin
         kx[i] = 46'(ix[i]) * 46'(HASH_K);
         ky[i] = 46'(iy[i]) * 46'(HASH_K);
         px_in[i] = kx[i][23:0];
         py_in[i] = ky[i][23:0];
      end
      fxs = 48'(in_x[23:0]) * 48'(in_x[23:0]);
      fys = 48'(in_y[23:0]) * 48'(in_y[23:0]);
      fx2_in = fxs[47:24];
      fy2_in = fys[47:24];

      // corners: (ix,iy), (ix+1,iy), (ix,iy+1), (ix+1,iy+1)
      cpx_in[0] = px_ff[0];
      cpx_in[1] = px_ff[1];
      cpx_in[2] = px_ff[0];
      cpx_in[3] = px_ff[1];
      cpy_in[0] = py_ff[0];
      cpy_in[1] = py_ff[0];
      cpy_in[2] = py_ff[1];
      cpy_in[3] = py_ff[1];
      for (int j = 0; j < 4; j++) begin
         p1 = 51'(27'(cpy_in[j]) + 27'(HASH_C)) * 51'(cpx_in[j]);
         p2 = 51'(27'(cpx_in[j]) + 27'(HASH_C)) * 51'(cpy_in[j]);
         p3 = 51'(27'(cpx_in[j]) + 27'(HASH_C)) * 51'(cpx_in[j]);
         m1_in[j] = p1[50:24];
         m2_in[j] = p2[50:24];
         m3_in[j] = p3[50:24];
      end
      fxc = 48'(fx2_ff) * 48'(fx_ff);
      fyc = 48'(fy2_ff) * 48'(fy_ff);
      fx3_in = fxc[47:24];
      fy3_in = fyc[47:24];

      for (int j = 0; j < 4; j++) begin
         dot = 29'(m1_ff[j]) + 29'(m2_ff[j]) + 29'(m3_ff[j]);
         s01_in[j] = 30'(cpx_ff[j]) + 30'(cpy_ff[j]) + {dot, 1'b0};
         s2_in[j]  = 29'(cpx_ff[j]) + dot;
      end
      uxr = 26'({fx2b_ff, 1'b0}) + 26'(fx2b_ff) - 26'({fx3_ff, 1'b0});
      uyr = 26'({fy2b_ff, 1'b0}) + 26'(fy2b_ff) - 26'({fy3_ff, 1'b0});
      ux_in = (uxr > 26'(ONE_F)) ? ONE_F : uxr[24:0];
      uy_in = (uyr > 26'(ONE_F)) ? ONE_F : uyr[24:0];

      vx = ONE_F - ux_ff;
      vy = ONE_F - uy_ff;
      wx[0] = vx;
      wx[1] = ux_ff;
      wx[2] = vx;
      wx[3] = ux_ff;
      wy[0] = vy;
      wy[1] = vy;
      wy[2] = uy_ff;
      wy[3] = uy_ff;
      for (int j = 0; j < 4; j++) begin
         hp = 59'(s01_ff[j]) * 59'(s2_ff[j]);
         h_in[j] = hp[47:24];
         wp = 50'(wx[j]) * 50'(wy[j]);
         w_in[j] = wp[48:24];
         tp = 49'(h_ff[j]) * 49'(w_ff[j]);
         t_in[j] = tp[47:24];
      end

      noise = 26'(t_ff[0]) + 26'(t_ff[1]) + 26'(t_ff[2]) + 26'(t_ff[3]);
      out_sum_in = sum_ff[OCT_LAT-2] + (ctl.add_en ? 24'(noise >> SHIFT) : 24'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         sum_ff[0] <= in_sum;
         for (int s = 1; s < OCT_LAT - 1; s++) begin
            sum_ff[s] <= sum_ff[s-1];
         end
         sum_ff[OCT_LAT-1] <= out_sum_in;
         for (int i = 0; i < 2; i++) begin
            px_ff[i] <= px_in[i];
            py_ff[i] <= py_in[i];
         end
         fx_ff   <= in_x[23:0];
         fy_ff   <= in_y[23:0];
         fx2_ff  <= fx2_in;
         fy2_ff  <= fy2_in;
         fx2b_ff <= fx2_ff;
         fy2b_ff <= fy2_ff;
         fx3_ff  <= fx3_in;
         fy3_ff  <= fy3_in;
         for (int j = 0; j < 4; j++) begin
            m1_ff[j]  <= m1_in[j];
            m2_ff[j]  <= m2_in[j];
            m3_ff[j]  <= m3_in[j];
            cpx_ff[j] <= cpx_in[j];
            cpy_ff[j] <= cpy_in[j];
            s01_ff[j] <= s01_in[j];
            s2_ff[j]  <= s2_in[j];
            h_ff[j]   <= h_in[j];
            w_ff[j]   <= w_in[j];
            t_ff[j]   <= t_in[j];
         end
         ux_ff <= ux_in;
         uy_ff <= uy_in;
         // align the rotated point with the noise sum
         rx_ff[0] <= rot_x;
         ry_ff[0] <= rot_y;
         rx_ff[1] <= rx_ff[0];
         ry_ff[1] <= ry_ff[0];
      end
   end

   assign out_valid = valid_ff[OCT_LAT-1];
   assign out_x     = rx_ff[1];
   assign out_y     = ry_ff[1];
   assign out_sum   = sum_ff[OCT_LAT-1];
endmodule

FILE: rtl/fbm_out_buf.sv
// Two-entry result buffer that decouples the pipeline from the response side.
module fbm_out_buf (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic [15:0] push_data,
   output logic        full,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_noise_value
);
   import fbm_pkg::*;

   `include "fbm_value_noise_2d_assert.svh"

   logic [1:0]  count_ff, count_in;
   logic [15:0] head_ff, tail_ff;
   logic        pop;

   assign pop = (count_ff != 2'd0) && rsp_ready;

   always_comb begin
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && (count_ff == 2'd2)) begin
         head_ff <= tail_ff;
      end
      if (push) begin
         if ((count_ff == 2'd0) || ((count_ff == 2'd1) && pop)) begin
            head_ff <= push_data;
         end else begin
            tail_ff <= push_data;
         end
      end
   end

   assign full            = (count_ff == 2'd2);
   assign rsp_valid       = (count_ff != 2'd0);
   assign rsp_noise_value = head_ff;

   `FBM_ASSERT(a_count_range, count_ff != 2'd3, "result buffer count out of range")
   `FBM_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result offered right after reset")
   `FBM_ASSERT(a_no_push_full, full |-> !push, "request pushed into full result buffer")
   `FBM_ASSERT(a_pop_frees, pop |=> count_ff != 2'd2, "result buffer full right after a pop")
endmodule

FILE: tb/tb_top.sv
// Testbench for the fractal value noise block: directed, configuration and random tests.
`timescale 1ns / 1ps

module tb_top;
   import fbm_pkg::*;

   localparam int OCTAVE_LIMIT = 8;
   localparam int DRAIN_CYCLES = 6 * OCTAVE_LIMIT + 12;
   localparam longint CYCLE_LIMIT = 1_000_000;
   localparam logic [63:0] MASK24 = 64'hFF_FFFF;
   localparam logic [63:0] UNIT24 = 64'h100_0000;
   localparam logic [63:0] LAT_K = (64'd13 << 24) / 64'd100;
   localparam logic [63:0] LAT_C = (64'd3 << 24) + ((64'd333 << 24) / 64'd1000);
   localparam logic [63:0] COS_Q32 = 64'd3769188402;
   localparam logic [63:0] SIN_Q32 = 64'd2059117009;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_x_coord = '0;
   logic signed [31:0] req_y_coord = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [15:0] rsp_noise_value;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_index_type csr_index = CSR_OCTAVE_COUNT;
   logic [7:0] csr_data = '0;

   logic [3:0] octave_setting = OCTAVE_COUNT_RESET;
   logic [7:0] offset_setting = OCTAVE_OFFSET_RESET;
   logic [15:0] noise_expected[$];
   int mismatch_count = 0;
   int request_count = 0;
   int result_count = 0;
   int rsp_hold_cycles = 0;
   longint cycle_count = 0;

   fbm_value_noise_2d #(.MAX_OCTAVES(OCTAVE_LIMIT)) i_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   // Q24 fixed-point helpers, all modulo 2^64
   function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
      return (a >> 24) * b + (((a & MASK24) * b) >> 24);
   endfunction

   function automatic logic [63:0] rot_mul(logic [63:0] v, logic [63:0] c);
      logic [63:0] hi;
      logic [63:0] lo;
      hi = {{32{v[63]}}, v[63:32]};
      lo = {32'd0, v[31:0]};
      return hi * c + ((lo * c) >> 32);
   endfunction

   function automatic logic [63:0] lattice_hash(logic [63:0] ix, logic [63:0] iy);
      logic [63:0] px;
      logic [63:0] py;
      logic [63:0] dp;
      logic [63:0] prod;
      px = (ix * LAT_K) & MASK24;
      py = (iy * LAT_K) & MASK24;
      dp = fx_mul(py + LAT_C, px) + fx_mul(px + LAT_C, py) + fx_mul(px + LAT_C, px);
      prod = ((px + dp) + (py + dp)) * (px + dp);
      return (prod >> 24) & MASK24;
   endfunction

   function automatic logic [63:0] fade(logic [63:0] f);
      logic [63:0] f2;
      logic [63:0] u;
      f2 = fx_mul(f, f);
      u = 64'd3 * f2 - 64'd2 * fx_mul(f2, f);
      return (u > UNIT24) ? UNIT24 : u;
   endfunction

   function automatic logic [63:0] cell_noise(logic [63:0] x, logic [63:0] y);
      logic [63:0] ix, iy, ux, uy, vx, vy;
      ix = x >> 24;
      iy = y >> 24;
      ux = fade(x & MASK24);
      uy = fade(y & MASK24);
      vx = UNIT24 - ux;
      vy = UNIT24 - uy;
      return fx_mul(lattice_hash(ix, iy), fx_mul(vx, vy))
           + fx_mul(lattice_hash(ix + 1, iy), fx_mul(ux, vy))
           + fx_mul(lattice_hash(ix, iy + 1), fx_mul(vx, uy))
           + fx_mul(lattice_hash(ix + 1, iy + 1), fx_mul(ux, uy));
   endfunction

   function automatic logic [15:0] fbm_noise(logic signed [31:0] xc, logic signed [31:0] yc);
      logic [63:0] x, y, nx, ny, acc, shift;
      int octaves;
      x = 64'(xc) << 8;
      y = 64'(yc) << 8;
      shift = 64'(offset_setting) << 24;
      acc = '0;
      octaves = octave_setting;
      if (octaves < 1) octaves = 1;
      if (octaves > OCTAVE_LIMIT) octaves = OCTAVE_LIMIT;
      for (int k = 0; k < octaves; k++) begin
         acc += cell_noise(x, y) >> (k + 1);
         nx = rot_mul(x, COS_Q32) - rot_mul(y, SIN_Q32);
         ny = rot_mul(x, SIN_Q32) + rot_mul(y, COS_Q32);
         x = 64'd2 * nx + shift;
         y = 64'd2 * ny + shift;
      end
      return acc[23:8];
   endfunction

   // Receiver: random stalls, or a long hold-off when requested
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_cycles <= rsp_hold_cycles - 1;
      end else if ($urandom_range(0, 99) < 70) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         result_count++;
         if (noise_expected.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected result noise_value=%h", rsp_noise_value);
         end else begin
            logic [15:0] want;
            want = noise_expected.pop_front();
            if (want !== rsp_noise_value) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch noise_value: expected %h actual %h", want,
                           rsp_noise_value);
            end
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Offer one request and hold it until accepted; called just after a falling edge
   task automatic send_point(logic signed [31:0] xc, logic signed [31:0] yc, int gap);
      req_valid <= 1'b1;
      req_x_coord <= xc;
      req_y_coord <= yc;
      do @(posedge clock); while (!req_ready);
      noise_expected.push_back(fbm_noise(xc, yc));
      request_count++;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (noise_expected.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Deassert csr_valid after each write so back-to-back writes stay distinct
   task automatic write_csr(csr_index_type idx, logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_OCTAVE_COUNT) octave_setting = value[3:0];
      else if (idx == CSR_OCTAVE_OFFSET) offset_setting = value;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic test_field_extremes();
      logic signed [31:0] corners[8];
      corners = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sh1, 32'sh0000_FFFF,
                  32'sh0001_0000, -32'sh0001_0000, 32'sh5555_AAAA};
      for (int i = 0; i < 8; i++)
         send_point(corners[i], corners[(i * 3 + 1) % 8], pick_gap());
      drain();
   endtask

   task automatic test_octave_settings();
      logic [7:0] counts[6];
      counts = '{8'd0, 8'd1, 8'd8, 8'd9, 8'd15, 8'hF3};
      for (int i = 0; i < 6; i++) begin
         write_csr(CSR_OCTAVE_COUNT, counts[i]);
         write_csr(CSR_OCTAVE_OFFSET, (i % 2) ? 8'd255 : 8'd0);
         send_point(-32'sh0002_8000, 32'sh0003_4000, 0);
         send_point(32'sh7FFF_FFFF, 32'sh8000_0000, pick_gap());
         drain();
      end
   endtask

   task automatic test_random(int items);
      for (int i = 0; i < items; i++) begin
         logic signed [31:0] xc, yc;
         if ($urandom_range(0, 1)) begin
            xc = $urandom;
            yc = $urandom;
         end else begin
            xc = $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
            yc = $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
         end
         if (i % 400 == 399) begin
            drain();
            write_csr(CSR_OCTAVE_COUNT, 8'($urandom_range(0, 255)));
            write_csr(CSR_OCTAVE_OFFSET, 8'($urandom));
         end
         send_point(xc, yc, (i % 100 < 30) ? 0 : pick_gap());
      end
      drain();
   endtask

   task automatic test_backpressure();
      rsp_hold_cycles = 200;
      for (int i = 0; i < 80; i++) send_point($urandom, $urandom, 0);
      drain();
   endtask

   task automatic test_pause_until_empty();
      for (int i = 0; i < 10; i++) send_point($urandom, $urandom, 0);
      req_valid <= 1'b0;
      while (noise_expected.size() != 0) @(negedge clock);
      for (int i = 0; i < 10; i++) send_point($urandom, $urandom, pick_gap());
      drain();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (DRAIN_CYCLES) @(negedge clock);
      test_field_extremes();
      test_octave_settings();
      write_csr(CSR_OCTAVE_COUNT, 8'd8);
      write_csr(CSR_OCTAVE_OFFSET, 8'd100);
      test_backpressure();
      test_pause_until_empty();
      test_random(1900);
      $display("Covered %0d points and %0d results over field extremes, octave counts 0..15,",
               request_count, result_count);
      $display("offsets 0..255, long output stalls and random traffic gaps.");
      if (mismatch_count == 0 && noise_expected.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatch_count,
                  noise_expected.size());
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

FILE: files.f
+incdir+rtl
rtl/fbm_pkg.sv
rtl/fbm_rotate.sv
rtl/fbm_octave.sv
rtl/fbm_out_buf.sv
rtl/fbm_value_noise_2d.sv
tb/tb_top.sv
